@@ rtl/gtpd_pkg.sv @@
// ----------------------------------------------------------------------------
// gtpd_pkg
// Shared types, constants and elaboration-time tables for the GPS track
// point decimator: fixed-point format, CORDIC tables, datapath commands.
// ----------------------------------------------------------------------------
package gtpd_pkg;

    localparam int ANGLE_FRAC_BITS = 30;
    localparam int CORDIC_STEPS    = 24;
    localparam int SQRT_STEPS      = ANGLE_FRAC_BITS + 1;
    localparam int FX_W            = 36;
    localparam int DEG_W           = 34;
    localparam int MUL_W           = 32;
    localparam int PROD_W          = 2 * MUL_W;
    localparam int CNT_W           = $clog2(SQRT_STEPS);
    localparam int ATAB_IDX_W      = $clog2(CORDIC_STEPS);
    localparam int SRC_W           = 2 * ANGLE_FRAC_BITS + 2;

    typedef logic signed [FX_W-1:0]  fx_t;
    typedef logic signed [DEG_W-1:0] deg_t;
    typedef fx_t atan_tab_t [CORDIC_STEPS];

    localparam longint unsigned PI_Q61 = 64'd7244019458077122842;

    localparam fx_t PI_F = fx_t'((PI_Q61 + (64'd1 << (60 - ANGLE_FRAC_BITS)))
                                 >> (61 - ANGLE_FRAC_BITS));
    localparam fx_t HALF_PI = fx_t'((PI_Q61 + (64'd1 << (61 - ANGLE_FRAC_BITS)))
                                    >> (62 - ANGLE_FRAC_BITS));
    localparam fx_t FX_ONE = fx_t'(64'd1 << ANGLE_FRAC_BITS);
    localparam logic [MUL_W-1:0] DEG_C =
        MUL_W'((PI_Q61 + 64'd900000000) / 64'd1800000000);
    localparam logic [MUL_W-1:0] EARTH_RADIUS_CM = 32'd637100000;
    localparam deg_t DEG_TURN      = 34'sd3600000000;
    localparam deg_t DEG_HALF_TURN = 34'sd1800000000;

    typedef enum logic [1:0] {
        OUT_IGNORED   = 2'd0,
        OUT_TOO_CLOSE = 2'd1,
        OUT_RECORDED  = 2'd2,
        OUT_SEQ_ZERO  = 2'd3
    } outcome_t;

    localparam int REG_MIN_SPACING = 0;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_WRAP,
        OP_CONV_MUL,
        OP_CONV,
        OP_ROT_INIT,
        OP_ROT_STEP,
        OP_ROT_STORE,
        OP_PROD_MUL,
        OP_PROD_STORE,
        OP_A_SUM,
        OP_SQ_INIT,
        OP_SQ_STEP,
        OP_SQ_STORE,
        OP_VEC_INIT,
        OP_VEC_STEP,
        OP_DIST_MUL,
        OP_DIST_STORE,
        OP_COMMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t           op;
        logic [1:0]       sel;
        logic [CNT_W-1:0] iter;
    } dp_cmd_t;

    typedef struct packed {
        logic need_seg;
        logic out_busy;
    } dp_status_t;

    function automatic longint unsigned q62_to_qf(longint unsigned v);
        return (v + (64'd1 << (61 - ANGLE_FRAC_BITS))) >> (62 - ANGLE_FRAC_BITS);
    endfunction

    // shift-and-subtract quotient for the elaboration-time tables
    function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 64'd0;
        r = 64'd0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], n[b]};
            if (r >= d)
            begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) by power series in Q62, rounded to the working format
    function automatic atan_tab_t build_atan();
        atan_tab_t tab;
        longint unsigned s;
        longint unsigned t;
        longint unsigned dv;
        int k;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            s = 64'd0;
            if (i == 0)
            begin
                s = PI_Q61 >> 1;
            end
            else
            begin
                for (k = 0; i * (2 * k + 1) <= 62; k++)
                begin
                    dv = 64'(2 * k + 1);
                    t  = udiv64(64'd1 << (62 - i * (2 * k + 1)), dv);
                    if (k[0])
                        s = s - t;
                    else
                        s = s + t;
                end
            end
            tab[i] = fx_t'(q62_to_qf(s));
        end
        return tab;
    endfunction

    function automatic fx_t build_gain();
        longint unsigned p;
        longint unsigned v;
        longint unsigned root;
        longint unsigned rem;
        longint unsigned trial;
        longint unsigned hb;
        longint unsigned lb;
        p = 64'd1 << 62;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (2 * i <= 60)
                p = p - udiv64(p, (64'd1 << (2 * i)) + 64'd1);
        end
        v    = q62_to_qf(p);
        root = 64'd0;
        rem  = 64'd0;
        for (int k = ANGLE_FRAC_BITS; k >= 0; k--)
        begin
            hb = (2 * k + 1 >= ANGLE_FRAC_BITS) ?
                 ((v >> (2 * k + 1 - ANGLE_FRAC_BITS)) & 64'd1) : 64'd0;
            lb = (2 * k >= ANGLE_FRAC_BITS) ?
                 ((v >> (2 * k - ANGLE_FRAC_BITS)) & 64'd1) : 64'd0;
            trial = (root << 2) | 64'd1;
            rem   = (rem << 2) | (hb << 1) | lb;
            if (rem >= trial)
            begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end
            else
            begin
                root = root << 1;
            end
        end
        return fx_t'(root);
    endfunction

    localparam atan_tab_t ATAN_TAB = build_atan();
    localparam fx_t CORDIC_GAIN = build_gain();

endpackage

@@ rtl/gtpd_fix_if.sv @@
// ----------------------------------------------------------------------------
// gtpd_fix_if
// Input channel: one GPS fix per transaction.
// ----------------------------------------------------------------------------
interface gtpd_fix_if;
    logic               valid;
    logic               ready;
    logic signed [30:0] latitude_e7;
    logic signed [31:0] longitude_e7;
    logic [31:0]        fix_sequence;
    logic               fix_ok;
    logic [31:0]        integrated_distance_cm;

    modport source (
        output valid, latitude_e7, longitude_e7, fix_sequence, fix_ok,
               integrated_distance_cm,
        input  ready
    );
    modport sink (
        input  valid, latitude_e7, longitude_e7, fix_sequence, fix_ok,
               integrated_distance_cm,
        output ready
    );
endinterface

@@ rtl/gtpd_res_if.sv @@
// ----------------------------------------------------------------------------
// gtpd_res_if
// Result channel: one decision and trip summary per transaction.
// ----------------------------------------------------------------------------
interface gtpd_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  outcome;
    logic [31:0] segment_cm;
    logic [31:0] trip_total_cm;
    logic [31:0] points_recorded;

    modport source (
        output valid, outcome, segment_cm, trip_total_cm, points_recorded,
        input  ready
    );
    modport sink (
        input  valid, outcome, segment_cm, trip_total_cm, points_recorded,
        output ready
    );
endinterface

@@ rtl/gtpd_ctrl.sv @@
// ----------------------------------------------------------------------------
// gtpd_ctrl
// Sequencer: steps the datapath through decision, angle conversion, four
// CORDIC rotations, products, two square roots, vectoring and commit.
// ----------------------------------------------------------------------------
module gtpd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fix_offered,
    output logic                 fix_ready,
    input  gtpd_pkg::dp_status_t status,
    output gtpd_pkg::dp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_DECIDE, S_WRAP, S_CMUL, S_CONV, S_RINIT, S_RSTEP, S_RSTORE,
        S_PMUL, S_PSTORE, S_ASUM, S_SQINIT, S_SQSTEP, S_SQSTORE, S_VINIT,
        S_VSTEP, S_DMUL, S_DSTORE, S_COMMIT
    } state_t;

    localparam logic [gtpd_pkg::CNT_W-1:0] CORDIC_LAST =
        gtpd_pkg::CNT_W'(gtpd_pkg::CORDIC_STEPS - 1);
    localparam logic [gtpd_pkg::CNT_W-1:0] SQRT_LAST =
        gtpd_pkg::CNT_W'(gtpd_pkg::SQRT_STEPS - 1);
    localparam logic [1:0] SEL_LAST_ANGLE = 2'd3;
    localparam logic [1:0] SEL_LAST_ROOT  = 2'd1;

    state_t                       state_reg, state_next;
    logic [1:0]                   sel_reg, sel_next;
    logic [gtpd_pkg::CNT_W-1:0]   cnt_reg, cnt_next;

    assign fix_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cnt_next   = cnt_reg;
        cmd.op     = gtpd_pkg::OP_NONE;
        cmd.sel    = sel_reg;
        cmd.iter   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (fix_offered)
                begin
                    cmd.op     = gtpd_pkg::OP_LOAD;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                sel_next   = 2'd0;
                state_next = status.need_seg ? S_WRAP : S_COMMIT;
            end
            S_WRAP:
            begin
                cmd.op     = gtpd_pkg::OP_WRAP;
                state_next = S_CMUL;
            end
            S_CMUL:
            begin
                cmd.op     = gtpd_pkg::OP_CONV_MUL;
                state_next = S_CONV;
            end
            S_CONV:
            begin
                cmd.op     = gtpd_pkg::OP_CONV;
                state_next = S_RINIT;
            end
            S_RINIT:
            begin
                cmd.op     = gtpd_pkg::OP_ROT_INIT;
                cnt_next   = '0;
                state_next = S_RSTEP;
            end
            S_RSTEP:
            begin
                cmd.op = gtpd_pkg::OP_ROT_STEP;
                if (cnt_reg == CORDIC_LAST)
                    state_next = S_RSTORE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_RSTORE:
            begin
                cmd.op = gtpd_pkg::OP_ROT_STORE;
                if (sel_reg == SEL_LAST_ANGLE)
                begin
                    sel_next   = 2'd0;
                    state_next = S_PMUL;
                end
                else
                begin
                    sel_next   = sel_reg + 1'b1;
                    state_next = S_WRAP;
                end
            end
            S_PMUL:
            begin
                cmd.op     = gtpd_pkg::OP_PROD_MUL;
                state_next = S_PSTORE;
            end
            S_PSTORE:
            begin
                cmd.op = gtpd_pkg::OP_PROD_STORE;
                if (sel_reg == SEL_LAST_ANGLE)
                    state_next = S_ASUM;
                else
                begin
                    sel_next   = sel_reg + 1'b1;
                    state_next = S_PMUL;
                end
            end
            S_ASUM:
            begin
                cmd.op     = gtpd_pkg::OP_A_SUM;
                sel_next   = 2'd0;
                state_next = S_SQINIT;
            end
            S_SQINIT:
            begin
                cmd.op     = gtpd_pkg::OP_SQ_INIT;
                cnt_next   = '0;
                state_next = S_SQSTEP;
            end
            S_SQSTEP:
            begin
                cmd.op = gtpd_pkg::OP_SQ_STEP;
                if (cnt_reg == SQRT_LAST)
                    state_next = S_SQSTORE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_SQSTORE:
            begin
                cmd.op = gtpd_pkg::OP_SQ_STORE;
                if (sel_reg == SEL_LAST_ROOT)
                    state_next = S_VINIT;
                else
                begin
                    sel_next   = sel_reg + 1'b1;
                    state_next = S_SQINIT;
                end
            end
            S_VINIT:
            begin
                cmd.op     = gtpd_pkg::OP_VEC_INIT;
                cnt_next   = '0;
                state_next = S_VSTEP;
            end
            S_VSTEP:
            begin
                cmd.op = gtpd_pkg::OP_VEC_STEP;
                if (cnt_reg == CORDIC_LAST)
                    state_next = S_DMUL;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_DMUL:
            begin
                cmd.op     = gtpd_pkg::OP_DIST_MUL;
                state_next = S_DSTORE;
            end
            S_DSTORE:
            begin
                cmd.op     = gtpd_pkg::OP_DIST_STORE;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                // hold until the output register is free
                if (!status.out_busy)
                begin
                    cmd.op     = gtpd_pkg::OP_COMMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= 2'd0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

@@ rtl/gtpd_dp.sv @@
// ----------------------------------------------------------------------------
// gtpd_dp
// Datapath: track state, decision logic, shared multiplier, shared CORDIC
// unit, bit-pair square root and the output register.
// ----------------------------------------------------------------------------
module gtpd_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gtpd_pkg::dp_cmd_t    cmd,
    output gtpd_pkg::dp_status_t status,
    input  logic [19:0]          min_spacing_cm,
    input  logic signed [30:0]   latitude_e7,
    input  logic signed [31:0]   longitude_e7,
    input  logic [31:0]          fix_sequence,
    input  logic                 fix_ok,
    input  logic [31:0]          integrated_distance_cm,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           outcome,
    output logic [31:0]          segment_cm,
    output logic [31:0]          trip_total_cm,
    output logic [31:0]          points_recorded
);

    localparam int F  = gtpd_pkg::ANGLE_FRAC_BITS;
    localparam int MW = gtpd_pkg::MUL_W;
    localparam int PW = gtpd_pkg::PROD_W;

    function automatic logic [PW-1:0] round_shift(logic [PW-1:0] p, int sh);
        logic [PW:0] s;
        s = {1'b0, p} + ((PW + 1)'(1) << (sh - 1));
        return PW'(s >> sh);
    endfunction

    function automatic logic [MW-1:0] mag(gtpd_pkg::fx_t v);
        gtpd_pkg::fx_t a;
        a = (v < 0) ? -v : v;
        return a[MW-1:0];
    endfunction

    // current item
    logic signed [30:0] lat_reg;
    logic signed [31:0] lon_reg;
    logic [31:0]        seq_reg;
    logic               ok_reg;
    logic [31:0]        integ_reg;

    // track state
    logic [31:0]        prev_seq_reg;
    logic               have_prev_reg;
    logic signed [30:0] prev_lat_reg;
    logic signed [31:0] prev_lon_reg;
    logic [31:0]        dist_last_reg;
    logic [31:0]        trip_reg;
    logic [31:0]        count_reg;

    // working registers
    gtpd_pkg::deg_t      deg_reg;
    logic [PW-1:0]       prod_reg;
    logic                neg_reg;
    gtpd_pkg::fx_t       ang_reg;
    gtpd_pkg::fx_t       x_reg, y_reg, z_reg;
    logic                flip_reg;
    gtpd_pkg::fx_t       trig_reg [4];
    gtpd_pkg::fx_t       m_reg [4];
    gtpd_pkg::fx_t       a_reg;
    logic [gtpd_pkg::SRC_W-1:0] src_reg;
    gtpd_pkg::fx_t       root_acc_reg;
    gtpd_pkg::fx_t       rem_reg;
    gtpd_pkg::fx_t       root_reg [2];
    logic [31:0]         seg_reg;

    logic                out_valid_reg;
    gtpd_pkg::outcome_t  outcome_reg;
    logic [31:0]         out_seg_reg;
    logic [31:0]         out_trip_reg;
    logic [31:0]         out_count_reg;

    // decision
    logic               is_ignored, is_zero, is_close;
    logic signed [32:0] advance;

    assign advance    = $signed({1'b0, integ_reg}) - $signed({1'b0, dist_last_reg});
    assign is_ignored = !ok_reg || (seq_reg == prev_seq_reg);
    assign is_zero    = (seq_reg == 32'd0);
    assign is_close   = have_prev_reg && (advance < $signed({13'd0, min_spacing_cm}));

    assign status.need_seg = !is_ignored && !is_zero && !is_close && have_prev_reg;
    assign status.out_busy = out_valid_reg && !out_ready;

    // angle wrap into [-180, 180) degrees
    gtpd_pkg::deg_t wrap_in, wrap_a, wrap_out;

    always_comb
    begin
        unique case (cmd.sel)
            2'd0:    wrap_in = gtpd_pkg::deg_t'(lat_reg) - gtpd_pkg::deg_t'(prev_lat_reg);
            2'd1:    wrap_in = gtpd_pkg::deg_t'(lon_reg) - gtpd_pkg::deg_t'(prev_lon_reg);
            2'd2:    wrap_in = gtpd_pkg::deg_t'(prev_lat_reg);
            default: wrap_in = gtpd_pkg::deg_t'(lat_reg);
        endcase
        if (wrap_in >= gtpd_pkg::DEG_TURN)
            wrap_a = wrap_in - gtpd_pkg::DEG_TURN;
        else if (wrap_in <= -gtpd_pkg::DEG_TURN)
            wrap_a = wrap_in + gtpd_pkg::DEG_TURN;
        else
            wrap_a = wrap_in;
        if (wrap_a >= gtpd_pkg::DEG_HALF_TURN)
            wrap_out = wrap_a - gtpd_pkg::DEG_TURN;
        else if (wrap_a < -gtpd_pkg::DEG_HALF_TURN)
            wrap_out = wrap_a + gtpd_pkg::DEG_TURN;
        else
            wrap_out = wrap_a;
    end

    // shared multiplier operand select
    logic [MW-1:0]  mul_a, mul_b;
    logic           mul_neg;
    gtpd_pkg::deg_t deg_abs;
    gtpd_pkg::fx_t  z_clamp;
    gtpd_pkg::fx_t  op_a, op_b;

    always_comb
    begin
        deg_abs = (deg_reg < 0) ? -deg_reg : deg_reg;
        if (z_reg < 0)
            z_clamp = '0;
        else if (z_reg > gtpd_pkg::HALF_PI)
            z_clamp = gtpd_pkg::HALF_PI;
        else
            z_clamp = z_reg;
        unique case (cmd.sel)
            2'd0:
            begin
                op_a = trig_reg[0];
                op_b = trig_reg[0];
            end
            2'd1:
            begin
                op_a = trig_reg[2];
                op_b = trig_reg[3];
            end
            2'd2:
            begin
                op_a = trig_reg[1];
                op_b = trig_reg[1];
            end
            default:
            begin
                op_a = m_reg[1];
                op_b = m_reg[2];
            end
        endcase
        if (cmd.op == gtpd_pkg::OP_CONV_MUL)
        begin
            mul_a   = deg_abs[MW-1:0];
            mul_b   = gtpd_pkg::DEG_C;
            mul_neg = (deg_reg < 0);
        end
        else if (cmd.op == gtpd_pkg::OP_DIST_MUL)
        begin
            mul_a   = {z_clamp[MW-2:0], 1'b0};
            mul_b   = gtpd_pkg::EARTH_RADIUS_CM;
            mul_neg = 1'b0;
        end
        else
        begin
            mul_a   = mag(op_a);
            mul_b   = mag(op_b);
            mul_neg = (op_a < 0) != (op_b < 0);
        end
    end

    // rounding after the multiplier
    logic [PW-1:0] conv_r, prod_r;
    gtpd_pkg::fx_t conv_val, prod_val;

    always_comb
    begin
        conv_r   = (cmd.sel[1] == 1'b0) ? round_shift(prod_reg, 62 - F)
                                        : round_shift(prod_reg, 61 - F);
        prod_r   = round_shift(prod_reg, F);
        conv_val = neg_reg ? -$signed(conv_r[gtpd_pkg::FX_W-1:0])
                           :  $signed(conv_r[gtpd_pkg::FX_W-1:0]);
        prod_val = neg_reg ? -$signed(prod_r[gtpd_pkg::FX_W-1:0])
                           :  $signed(prod_r[gtpd_pkg::FX_W-1:0]);
    end

    // CORDIC step
    gtpd_pkg::fx_t dx, dy, atab_e;

    assign dx     = y_reg >>> cmd.iter;
    assign dy     = x_reg >>> cmd.iter;
    assign atab_e = gtpd_pkg::ATAN_TAB[cmd.iter[gtpd_pkg::ATAB_IDX_W-1:0]];

    // square root step
    gtpd_pkg::fx_t sq_rem2, sq_trial, sq_v, a_sum;

    always_comb
    begin
        sq_rem2  = {rem_reg[gtpd_pkg::FX_W-3:0], src_reg[gtpd_pkg::SRC_W-1 -: 2]};
        sq_trial = {root_acc_reg[gtpd_pkg::FX_W-3:0], 2'b01};
        sq_v     = (cmd.sel[0] == 1'b1) ? gtpd_pkg::FX_ONE - a_reg : a_reg;
        a_sum    = m_reg[0] + m_reg[3];
    end

    // commit values
    logic [31:0] seg_add;
    logic [32:0] trip_sum;

    assign seg_add  = have_prev_reg ? seg_reg : 32'd0;
    assign trip_sum = {1'b0, trip_reg} + {1'b0, seg_add};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_seq_reg  <= '0;
            have_prev_reg <= 1'b0;
            prev_lat_reg  <= '0;
            prev_lon_reg  <= '0;
            dist_last_reg <= '0;
            trip_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.op == gtpd_pkg::OP_COMMIT)
            begin
                out_valid_reg <= 1'b1;
                if (!is_ignored && !is_zero)
                begin
                    prev_seq_reg <= seq_reg;
                    if (!is_close)
                    begin
                        have_prev_reg <= 1'b1;
                        prev_lat_reg  <= lat_reg;
                        prev_lon_reg  <= lon_reg;
                        dist_last_reg <= integ_reg;
                        trip_reg      <= trip_sum[32] ? '1 : trip_sum[31:0];
                        if (count_reg != '1)
                            count_reg <= count_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            gtpd_pkg::OP_LOAD:
            begin
                lat_reg   <= latitude_e7;
                lon_reg   <= longitude_e7;
                seq_reg   <= fix_sequence;
                ok_reg    <= fix_ok;
                integ_reg <= integrated_distance_cm;
            end
            gtpd_pkg::OP_WRAP:
            begin
                deg_reg <= wrap_out;
            end
            gtpd_pkg::OP_CONV_MUL, gtpd_pkg::OP_PROD_MUL, gtpd_pkg::OP_DIST_MUL:
            begin
                prod_reg <= mul_a * mul_b;
                neg_reg  <= mul_neg;
            end
            gtpd_pkg::OP_CONV:
            begin
                ang_reg <= conv_val;
            end
            gtpd_pkg::OP_ROT_INIT:
            begin
                x_reg <= gtpd_pkg::CORDIC_GAIN;
                y_reg <= '0;
                // fold the angle into [-pi/2, pi/2], negate results later
                if (ang_reg > gtpd_pkg::HALF_PI)
                begin
                    z_reg    <= ang_reg - gtpd_pkg::PI_F;
                    flip_reg <= 1'b1;
                end
                else if (ang_reg < -gtpd_pkg::HALF_PI)
                begin
                    z_reg    <= ang_reg + gtpd_pkg::PI_F;
                    flip_reg <= 1'b1;
                end
                else
                begin
                    z_reg    <= ang_reg;
                    flip_reg <= 1'b0;
                end
            end
            gtpd_pkg::OP_ROT_STEP:
            begin
                if (z_reg >= 0)
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - atab_e;
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + atab_e;
                end
            end
            gtpd_pkg::OP_ROT_STORE:
            begin
                if (cmd.sel[1] == 1'b0)
                    trig_reg[cmd.sel] <= flip_reg ? -y_reg : y_reg;
                else
                    trig_reg[cmd.sel] <= flip_reg ? -x_reg : x_reg;
            end
            gtpd_pkg::OP_PROD_STORE:
            begin
                m_reg[cmd.sel] <= prod_val;
            end
            gtpd_pkg::OP_A_SUM:
            begin
                if (a_sum < 0)
                    a_reg <= '0;
                else if (a_sum > gtpd_pkg::FX_ONE)
                    a_reg <= gtpd_pkg::FX_ONE;
                else
                    a_reg <= a_sum;
            end
            gtpd_pkg::OP_SQ_INIT:
            begin
                src_reg      <= {1'b0, sq_v[F:0], {F{1'b0}}};
                root_acc_reg <= '0;
                rem_reg      <= '0;
            end
            gtpd_pkg::OP_SQ_STEP:
            begin
                src_reg <= src_reg << 2;
                if (sq_rem2 >= sq_trial)
                begin
                    rem_reg      <= sq_rem2 - sq_trial;
                    root_acc_reg <= {root_acc_reg[gtpd_pkg::FX_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg      <= sq_rem2;
                    root_acc_reg <= {root_acc_reg[gtpd_pkg::FX_W-2:0], 1'b0};
                end
            end
            gtpd_pkg::OP_SQ_STORE:
            begin
                root_reg[cmd.sel[0]] <= root_acc_reg;
            end
            gtpd_pkg::OP_VEC_INIT:
            begin
                x_reg <= root_reg[1];
                y_reg <= root_reg[0];
                z_reg <= '0;
            end
            gtpd_pkg::OP_VEC_STEP:
            begin
                if (y_reg > 0)
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + atab_e;
                end
                else
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - atab_e;
                end
            end
            gtpd_pkg::OP_DIST_STORE:
            begin
                seg_reg <= (prod_r[PW-1:32] != '0) ? '1 : prod_r[31:0];
            end
            gtpd_pkg::OP_COMMIT:
            begin
                out_trip_reg  <= trip_reg;
                out_count_reg <= count_reg;
                out_seg_reg   <= 32'd0;
                if (is_ignored)
                    outcome_reg <= gtpd_pkg::OUT_IGNORED;
                else if (is_zero)
                    outcome_reg <= gtpd_pkg::OUT_SEQ_ZERO;
                else if (is_close)
                    outcome_reg <= gtpd_pkg::OUT_TOO_CLOSE;
                else
                begin
                    outcome_reg   <= gtpd_pkg::OUT_RECORDED;
                    out_seg_reg   <= seg_add;
                    out_trip_reg  <= trip_sum[32] ? '1 : trip_sum[31:0];
                    out_count_reg <= (count_reg != '1) ? count_reg + 1'b1 : count_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid       = out_valid_reg;
    assign outcome         = outcome_reg;
    assign segment_cm      = out_seg_reg;
    assign trip_total_cm   = out_trip_reg;
    assign points_recorded = out_count_reg;

endmodule

@@ rtl/gps_track_point_decimator.sv @@
// ----------------------------------------------------------------------------
// gps_track_point_decimator
// Top level: APB register, sequencer and datapath.
// ----------------------------------------------------------------------------
// One GPS fix is taken per transaction and one result is returned for each.
// Invalid or repeated fixes, sequence zero, fixes too close to the last
// recorded point and the first recorded point go from the decide state
// straight to commit. A recorded fix with an earlier point runs the
// haversine on one shared CORDIC unit and one bit-pair square root unit:
// four rotations (wrap, scale, convert, fold, 24 steps and store), four
// products (multiply and store), the sum, two square roots (init, bit-pair
// steps and store), a vectoring pass and the decide, distance and commit
// steps, with a single 32x32 multiplier serving every product. A fix is
// taken only once the previous one is committed. A new fix is taken as soon
// as the previous result sits in the output register, even if it is not yet
// taken; its own result then waits until that register is free.
module gps_track_point_decimator (
    input  logic               clk,
    input  logic               rst_n,
    gtpd_fix_if.sink           fix,
    gtpd_res_if.source         result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    gtpd_pkg::dp_cmd_t    cmd;
    gtpd_pkg::dp_status_t status;
    logic [19:0]          min_spacing_reg;
    logic                 reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == 1'(gtpd_pkg::REG_MIN_SPACING));
    assign prdata  = reg_sel ? {12'd0, min_spacing_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_spacing_reg <= 20'd500;
        else if (psel && penable && pwrite && reg_sel)
            min_spacing_reg <= pwdata[19:0];
    end

    gtpd_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .fix_offered (fix.valid),
        .fix_ready   (fix.ready),
        .status      (status),
        .cmd         (cmd)
    );

    gtpd_dp u_dp (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .cmd                    (cmd),
        .status                 (status),
        .min_spacing_cm         (min_spacing_reg),
        .latitude_e7            (fix.latitude_e7),
        .longitude_e7           (fix.longitude_e7),
        .fix_sequence           (fix.fix_sequence),
        .fix_ok                 (fix.fix_ok),
        .integrated_distance_cm (fix.integrated_distance_cm),
        .out_valid              (result.valid),
        .out_ready              (result.ready),
        .outcome                (result.outcome),
        .segment_cm             (result.segment_cm),
        .trip_total_cm          (result.trip_total_cm),
        .points_recorded        (result.points_recorded)
    );

    // the sequencer leaves idle on every accepted fix
    assert property (@(posedge clk) disable iff (!rst_n)
        fix.valid && fix.ready |=> !fix.ready)
        else $error("fix accepted twice in a row");

    // only recorded fixes carry a segment
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.outcome != gtpd_pkg::OUT_RECORDED |-> result.segment_cm == 32'd0)
        else $error("segment on a fix that was not recorded");

endmodule
